FILE: design/tcpq_pkg.sv
// shared types and defaults for the two-class priority queue
// used by tcpq_cell, tcpq_fcell and two_class_priority_queue; no dependencies
package tcpq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_TICKET_BITS = 10;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} tcpq_status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} tcpq_action_t;

	// broadcast control for the main chain
	typedef struct packed {
		logic ins;
		logic rem;
		logic any_flag;
	} tcpq_ctl_t;

	// broadcast control for the priority-ticket chain
	typedef struct packed {
		logic ins;
		logic rem;
	} tcpq_fctl_t;

endpackage

FILE: design/tcpq_cell.sv
// one position of the main queue chain: ticket, flag and count of flagged entries ahead
// depends on tcpq_pkg
module tcpq_cell import tcpq_pkg::*; #(
	parameter int TICKET_BITS = DEF_TICKET_BITS,
	parameter int CW          = 5,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  tcpq_ctl_t              ctl,
	input  logic [CW-1:0]          count,
	input  logic [TICKET_BITS-1:0] in_ticket,
	input  logic                   in_prio,
	input  logic                   prev_flag,
	input  logic [CW-1:0]          prev_pc,
	input  logic [TICKET_BITS-1:0] next_ticket,
	input  logic                   next_flag,
	input  logic [CW-1:0]          next_pc,
	output logic [TICKET_BITS-1:0] ticket,
	output logic                   flag,
	output logic [CW-1:0]          pc
);

	logic [TICKET_BITS-1:0] ticket_q;
	logic                   flag_q;
	logic [CW-1:0]          pc_q;
	logic                   at_tail;
	logic                   shift;

	assign at_tail = (count == CW'(INDEX));
	// cells ahead of the first flagged entry hold still, the rest move up
	assign shift   = !ctl.any_flag || (pc_q != '0) || flag_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && at_tail) begin
			ticket_q <= in_ticket;
			flag_q   <= in_prio;
			pc_q     <= prev_pc + CW'(prev_flag);
		end else if (ctl.rem && shift) begin
			ticket_q <= next_ticket;
			flag_q   <= next_flag;
			pc_q     <= next_pc - CW'(ctl.any_flag);
		end
	end

	assign ticket = ticket_q;
	assign flag   = flag_q;
	assign pc     = pc_q;

endmodule

FILE: design/tcpq_fcell.sv
// one position of the priority-ticket chain, a shifting fifo of flagged tickets
// depends on tcpq_pkg
module tcpq_fcell import tcpq_pkg::*; #(
	parameter int TICKET_BITS = DEF_TICKET_BITS,
	parameter int CW          = 5,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  tcpq_fctl_t             ctl,
	input  logic [CW-1:0]          fcount,
	input  logic [TICKET_BITS-1:0] in_ticket,
	input  logic [TICKET_BITS-1:0] next_ticket,
	output logic [TICKET_BITS-1:0] ticket
);

	logic [TICKET_BITS-1:0] ticket_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && (fcount == CW'(INDEX))) begin
			ticket_q <= in_ticket;
		end else if (ctl.rem) begin
			ticket_q <= next_ticket;
		end
	end

	assign ticket = ticket_q;

endmodule

FILE: design/two_class_priority_queue.sv
// two-class priority queue: top level with counters, cell chains and result register
// depends on tcpq_pkg, tcpq_cell, tcpq_fcell
// a result is registered and valid in the cycle after its input transfer
// throughput: one item per cycle while in_ready is high; each insert or remove is applied
//   at once because each cell decides locally from its own flagged-ahead count and its neighbors
// reset: arst_n clears the entry counts and the result valid; the cell store has no
//   reset and no clearing pass, only cells below the count are ever read
module two_class_priority_queue import tcpq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TICKET_BITS = DEF_TICKET_BITS,
	localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   action,
	input  logic [TICKET_BITS-1:0] ticket,
	input  logic                   priority_req,
	// result channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [TICKET_BITS-1:0] served_ticket,
	output logic                   served_priority,
	output logic [CW-1:0]          occupancy,
	output logic                   is_empty,
	output logic                   is_full
);

	// fill state of the whole queue and of the flagged-ticket fifo
	logic [CW-1:0] count_q;
	logic [CW-1:0] fcount_q;

	// result register
	logic                   out_valid_q;
	tcpq_status_t           status_q;
	logic [TICKET_BITS-1:0] served_ticket_q;
	logic                   served_priority_q;
	logic [CW-1:0]          occupancy_q;
	logic                   is_empty_q;
	logic                   is_full_q;

	// cell outputs
	logic [TICKET_BITS-1:0] c_ticket [QUEUE_DEPTH];
	logic                   c_flag   [QUEUE_DEPTH];
	logic [CW-1:0]          c_pc     [QUEUE_DEPTH];
	logic [TICKET_BITS-1:0] f_ticket [QUEUE_DEPTH];

	logic          in_xfer;
	logic          q_full;
	logic          q_empty;
	logic          any_flag;
	logic          do_ins;
	logic          do_rem;
	tcpq_ctl_t     ctl;
	tcpq_fctl_t    fctl;
	logic [CW-1:0] count_next;

	// the result register frees up in the same cycle it is taken
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	assign q_full   = (count_q == CW'(QUEUE_DEPTH));
	assign q_empty  = (count_q == '0);
	// a nonempty flagged fifo means some held entry carries the priority flag
	assign any_flag = (fcount_q != '0);

	assign do_ins = in_xfer && (action == ACT_INSERT) && !q_full;
	assign do_rem = in_xfer && (action == ACT_REMOVE) && !q_empty;

	assign ctl.ins      = do_ins;
	assign ctl.rem      = do_rem;
	assign ctl.any_flag = any_flag;

	assign fctl.ins = do_ins && priority_req;
	assign fctl.rem = do_rem && any_flag;

	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + CW'(1);
		end else if (do_rem) begin
			count_next = count_q - CW'(1);
		end
	end

	// main chain: cell 0 is the head, insert lands at the cell equal to the count,
	// remove pulls every cell from the served one onward up by one place
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                   prev_flag;
		logic [CW-1:0]          prev_pc;
		logic [TICKET_BITS-1:0] next_ticket;
		logic                   next_flag;
		logic [CW-1:0]          next_pc;
		logic [TICKET_BITS-1:0] fnext_ticket;

		if (i == 0) begin : g_first
			assign prev_flag = 1'b0;
			assign prev_pc   = '0;
		end else begin : g_mid
			assign prev_flag = c_flag[i-1];
			assign prev_pc   = c_pc[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_ticket  = '0;
			assign next_flag    = 1'b0;
			assign next_pc      = '0;
			assign fnext_ticket = '0;
		end else begin : g_inner
			assign next_ticket  = c_ticket[i+1];
			assign next_flag    = c_flag[i+1];
			assign next_pc      = c_pc[i+1];
			assign fnext_ticket = f_ticket[i+1];
		end

		tcpq_cell #(
			.TICKET_BITS (TICKET_BITS),
			.CW          (CW),
			.INDEX       (i)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.count       (count_q),
			.in_ticket   (ticket),
			.in_prio     (priority_req),
			.prev_flag   (prev_flag),
			.prev_pc     (prev_pc),
			.next_ticket (next_ticket),
			.next_flag   (next_flag),
			.next_pc     (next_pc),
			.ticket      (c_ticket[i]),
			.flag        (c_flag[i]),
			.pc          (c_pc[i])
		);

		// flagged tickets in arrival order, head at cell 0
		tcpq_fcell #(
			.TICKET_BITS (TICKET_BITS),
			.CW          (CW),
			.INDEX       (i)
		) u_fcell (
			.clk         (clk),
			.ctl         (fctl),
			.fcount      (fcount_q),
			.in_ticket   (ticket),
			.next_ticket (fnext_ticket),
			.ticket      (f_ticket[i])
		);
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			fcount_q <= '0;
		end else begin
			count_q <= count_next;
			if (fctl.ins) begin
				fcount_q <= fcount_q + CW'(1);
			end else if (fctl.rem) begin
				fcount_q <= fcount_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded on every input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			served_ticket_q   <= '0;
			served_priority_q <= 1'b0;
			if (action == ACT_INSERT) begin
				status_q <= q_full ? ST_FULL : ST_INSERTED;
			end else if (q_empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_REMOVED;
				// oldest flagged entry first, else the head
				if (any_flag) begin
					served_ticket_q   <= f_ticket[0];
					served_priority_q <= 1'b1;
				end else begin
					served_ticket_q   <= c_ticket[0];
				end
			end
			occupancy_q <= count_next;
			is_empty_q  <= (count_next == '0);
			is_full_q   <= (count_next == CW'(QUEUE_DEPTH));
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign served_ticket   = served_ticket_q;
	assign served_priority = served_priority_q;
	assign occupancy       = occupancy_q;
	assign is_empty        = is_empty_q;
	assign is_full         = is_full_q;

endmodule
